// ===== sv/ttpo_pkg.sv =====
// shared types, codes and the ordering compare for the task table orderer
// no dependencies
package ttpo_pkg;

  localparam int CNT_W = 6;

  typedef struct packed {
    logic [15:0] ident;
    logic [15:0] duration;
    logic [15:0] deadline;
    logic [1:0]  prio;
  } entry_t;

  typedef enum logic [2:0] {
    FN_ADD   = 3'd0,
    FN_UPD   = 3'd1,
    FN_DEL   = 3'd2,
    FN_LIST  = 3'd3,
    FN_ORDER = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BAD       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KEY_DEADLINE = 2'd0,
    KEY_PRIORITY = 2'd1,
    KEY_DURATION = 2'd2,
    KEY_NONE     = 2'd3
  } key_t;

  typedef enum logic [1:0] {
    CM_HOLD = 2'd0,
    CM_LOAD = 2'd1,
    CM_ROT  = 2'd2,
    CM_SORT = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t       mode;
    logic [CNT_W-1:0] sel;
    logic             push;
    entry_t           push_ent;
    logic [CNT_W-1:0] len;
    logic             parity;
    logic [1:0]       key;
  } cell_ctrl_t;

  // a strictly before b under key
  function automatic logic goes_before(logic [1:0] key, entry_t a, entry_t b);
    logic r;
    case (key)
      KEY_DEADLINE: r = a.deadline < b.deadline;
      KEY_PRIORITY: r = a.prio > b.prio;
      default:      r = a.duration < b.duration;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/ttpo_cell.sv =====
// one table entry: load, rotate toward the head, or odd-even compare-exchange
// depends on ttpo_pkg
module ttpo_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  ttpo_pkg::cell_ctrl_t ctrl,
  input  ttpo_pkg::entry_t    left_i,
  input  ttpo_pkg::entry_t    right_i,
  output ttpo_pkg::entry_t    ent_o
);

  localparam logic [ttpo_pkg::CNT_W-1:0] MY_IDX = ttpo_pkg::CNT_W'(IDX);
  localparam logic [ttpo_pkg::CNT_W-1:0] NX_IDX = ttpo_pkg::CNT_W'(IDX + 1);
  localparam logic                       MY_PAR = 1'(IDX % 2);

  ttpo_pkg::entry_t ent_r;
  ttpo_pkg::entry_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    unique case (ctrl.mode)
      ttpo_pkg::CM_LOAD: begin
        if (ctrl.sel == MY_IDX) ent_nxt = ctrl.push_ent;
      end
      ttpo_pkg::CM_ROT: begin
        if (MY_IDX < ctrl.sel) ent_nxt = right_i;
        else if (MY_IDX == ctrl.sel && ctrl.push) ent_nxt = ctrl.push_ent;
      end
      ttpo_pkg::CM_SORT: begin
        if (MY_PAR == ctrl.parity) begin
          if (NX_IDX < ctrl.len && ttpo_pkg::goes_before(ctrl.key, right_i, ent_r))
            ent_nxt = right_i;
        end else begin
          if (IDX >= 1 && MY_IDX < ctrl.len && ttpo_pkg::goes_before(ctrl.key, ent_r, left_i))
            ent_nxt = left_i;
        end
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent_o = ent_r;

endmodule

// ===== sv/task_table_policy_orderer_core.sv =====
// task table orderer top: request decode, sequencing and the row of entry cells
// depends on ttpo_pkg and ttpo_cell
//
// in channel: one request item per handshake (add, update, delete, list, order)
// out channel: result items; tlast marks the final item of a request
// the table is a row of cells, cell 0 is the head; entries rotate toward it
// add and every error found at decode answer in the cycle after the item is taken
// update and delete walk the table, rotating each of the n stored entries past the head
// list emits n items, one per cycle the receiver takes
// order runs n odd-even compare-exchange phases, then emits n ids
// one request is worked on at a time; in_tready is low while a request runs
// or while a result item waits in the output register
// when the receiver stalls, the output register holds and the row of cells
// stops rotating until the item is taken
// reset empties the table (count zero) and clears the output valid; entry
// contents are not cleared and are never read before being written
module task_table_policy_orderer_core #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // func, task_ident, task_duration, task_deadline, task_priority, order_key
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status, out_ident, out_duration, out_deadline, out_priority
  output logic [55:0] out_tdata,
  output logic        out_tlast
);

  localparam int CW = ttpo_pkg::CNT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_SORT = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       len_r, len_nxt;
  logic [CW-1:0]       steps_r, steps_nxt;
  logic                found_r, found_nxt;
  logic                del_r, del_nxt;
  logic                full_r, full_nxt;
  logic                parity_r, parity_nxt;
  logic [1:0]          key_r, key_nxt;
  ttpo_pkg::entry_t    req_r, req_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [55:0]         out_data_r, out_data_nxt;
  logic                out_last_r, out_last_nxt;

  ttpo_pkg::cell_ctrl_t ctrl;
  ttpo_pkg::entry_t     ents [TABLE_DEPTH];
  ttpo_pkg::entry_t     head, new_ent;
  logic [2:0]           in_func;
  logic [1:0]           in_key;
  logic                 in_acc, out_free, match;

  assign head      = ents[0];
  assign in_func   = in_tdata[2:0];
  assign in_key    = in_tdata[54:53];
  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign match     = !found_r && head.ident == req_r.ident;

  always_comb begin
    new_ent.ident    = in_tdata[18:3];
    new_ent.duration = in_tdata[34:19];
    new_ent.deadline = in_tdata[50:35];
    new_ent.prio     = (in_tdata[52:51] == 2'd0) ? 2'd1 : in_tdata[52:51];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    len_nxt       = len_r;
    steps_nxt     = steps_r;
    found_nxt     = found_r;
    del_nxt       = del_r;
    full_nxt      = full_r;
    parity_nxt    = parity_r;
    key_nxt       = key_r;
    req_nxt       = req_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    ctrl          = '0;
    ctrl.mode     = ttpo_pkg::CM_HOLD;
    ctrl.key      = key_r;
    ctrl.parity   = parity_r;
    ctrl.len      = count_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_last_nxt  = 1'b1;
          case (in_func) inside
            ttpo_pkg::FN_ADD: begin
              if (count_r >= DEPTH_C) begin
                out_data_nxt[2:0] = ttpo_pkg::ST_FULL;
              end else begin
                ctrl.mode     = ttpo_pkg::CM_LOAD;
                ctrl.sel      = count_r;
                ctrl.push_ent = new_ent;
                count_nxt     = count_r + 1'b1;
                out_data_nxt[2:0] = ttpo_pkg::ST_OK;
              end
            end
            ttpo_pkg::FN_UPD, ttpo_pkg::FN_DEL: begin
              if (count_r == '0) begin
                out_data_nxt[2:0] = ttpo_pkg::ST_NOT_FOUND;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt = S_WALK;
                steps_nxt = count_r;
                len_nxt   = count_r;
                found_nxt = 1'b0;
                del_nxt   = (in_func == ttpo_pkg::FN_DEL);
                req_nxt   = new_ent;
              end
            end
            ttpo_pkg::FN_LIST: begin
              if (count_r == '0) begin
                out_data_nxt[2:0] = ttpo_pkg::ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt = S_EMIT;
                steps_nxt = count_r;
                full_nxt  = 1'b1;
              end
            end
            ttpo_pkg::FN_ORDER: begin
              if (in_key == ttpo_pkg::KEY_NONE) begin
                out_data_nxt[2:0] = ttpo_pkg::ST_BAD;
              end else if (count_r == '0) begin
                out_data_nxt[2:0] = ttpo_pkg::ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt  = S_SORT;
                steps_nxt  = count_r;
                parity_nxt = 1'b0;
                key_nxt    = in_key;
                full_nxt   = 1'b0;
              end
            end
            default: out_data_nxt[2:0] = ttpo_pkg::ST_BAD;
          endcase
        end
      end
      S_WALK: begin
        ctrl.mode = ttpo_pkg::CM_ROT;
        ctrl.sel  = len_r - 1'b1;
        ctrl.push = !(del_r && match);
        ctrl.push_ent = head;
        if (match && !del_r) begin
          ctrl.push_ent.duration = req_r.duration;
          ctrl.push_ent.deadline = req_r.deadline;
          ctrl.push_ent.prio     = req_r.prio;
        end
        if (match) found_nxt = 1'b1;
        if (match && del_r) len_nxt = len_r - 1'b1;
        steps_nxt = steps_r - 1'b1;
        if (steps_r == CW'(1)) begin
          state_nxt     = S_IDLE;
          count_nxt     = len_nxt;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_data_nxt[2:0] = (found_r || match) ? ttpo_pkg::ST_OK : ttpo_pkg::ST_NOT_FOUND;
        end
      end
      S_SORT: begin
        ctrl.mode  = ttpo_pkg::CM_SORT;
        parity_nxt = !parity_r;
        steps_nxt  = steps_r - 1'b1;
        if (steps_r == CW'(1)) begin
          state_nxt = S_EMIT;
          steps_nxt = count_r;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ctrl.mode     = ttpo_pkg::CM_ROT;
          ctrl.sel      = count_r - 1'b1;
          ctrl.push     = 1'b1;
          ctrl.push_ent = head;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[2:0]  = ttpo_pkg::ST_OK;
          out_data_nxt[18:3] = head.ident;
          if (full_r) begin
            out_data_nxt[34:19] = head.duration;
            out_data_nxt[50:35] = head.deadline;
            out_data_nxt[52:51] = head.prio;
          end
          out_last_nxt = (steps_r == CW'(1));
          steps_nxt    = steps_r - 1'b1;
          if (steps_r == CW'(1)) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      ttpo_cell #(.IDX(g)) u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .left_i  (ents[(g == 0) ? 0 : g - 1]),
        .right_i (ents[(g == TABLE_DEPTH - 1) ? g : g + 1]),
        .ent_o   (ents[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    len_r        <= len_nxt;
    steps_r      <= steps_nxt;
    found_r      <= found_nxt;
    del_r        <= del_nxt;
    full_r       <= full_nxt;
    parity_r     <= parity_nxt;
    key_r        <= key_nxt;
    req_r        <= req_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C) else $error("entry count above table depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (out_valid_r || state_r != S_IDLE)) else $error("request dropped");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !in_acc) |-> ctrl.mode == ttpo_pkg::CM_HOLD)
    else $error("table moved while idle");
`endif

endmodule

// ===== test/task_table_policy_orderer_core_tb.sv =====
// testbench for task_table_policy_orderer_core: directed and random requests
// checked against a behavioral task table kept in the testbench
// depends on ttpo_pkg and the core rtl
module task_table_policy_orderer_core_tb;

  localparam int DEPTH = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] ident;
    logic [15:0] duration;
    logic [15:0] deadline;
    logic [1:0]  prio;
    logic        last;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tlast;

  ttpo_pkg::entry_t table_q[$];
  answer_t answer_q[$];
  int      error_count;
  int      idle_cycles;
  bit      send_gaps;
  bit      recv_gaps;
  int      hold_off;
  bit      long_hold_req;
  bit      long_hold_ack;

  task_table_policy_orderer_core #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic answer_t plain_answer(ttpo_pkg::status_t st);
    answer_t a;
    a = '0;
    a.status = st;
    a.last = 1'b1;
    return a;
  endfunction

  function automatic bit sorts_ahead(logic [1:0] key, ttpo_pkg::entry_t a,
                                     ttpo_pkg::entry_t b);
    case (key)
      ttpo_pkg::KEY_DEADLINE: return a.deadline < b.deadline;
      ttpo_pkg::KEY_PRIORITY: return a.prio > b.prio;
      default:                return a.duration < b.duration;
    endcase
  endfunction

  function automatic int find_task(logic [15:0] id);
    for (int i = 0; i < table_q.size(); i++)
      if (table_q[i].ident == id) return i;
    return -1;
  endfunction

  task automatic queue_answer(answer_t a);
    answer_q.insert(answer_q.size(), a);
  endtask

  task automatic predict_request(logic [2:0] fn, ttpo_pkg::entry_t req, logic [1:0] key);
    int               idx;
    int               n;
    ttpo_pkg::entry_t tmp;
    answer_t          a;
    n = table_q.size();
    if (req.prio == 2'd0) req.prio = 2'd1;
    case (fn) inside
      ttpo_pkg::FN_ADD: begin
        if (n >= DEPTH) queue_answer(plain_answer(ttpo_pkg::ST_FULL));
        else begin
          table_q.insert(table_q.size(), req);
          queue_answer(plain_answer(ttpo_pkg::ST_OK));
        end
      end
      ttpo_pkg::FN_UPD, ttpo_pkg::FN_DEL: begin
        idx = find_task(req.ident);
        if (idx < 0) queue_answer(plain_answer(ttpo_pkg::ST_NOT_FOUND));
        else begin
          if (fn == ttpo_pkg::FN_DEL) table_q.delete(idx);
          else begin
            table_q[idx].duration = req.duration;
            table_q[idx].deadline = req.deadline;
            table_q[idx].prio = req.prio;
          end
          queue_answer(plain_answer(ttpo_pkg::ST_OK));
        end
      end
      ttpo_pkg::FN_LIST: begin
        if (n == 0) queue_answer(plain_answer(ttpo_pkg::ST_EMPTY));
        else
          for (int i = 0; i < n; i++) begin
            a.status = ttpo_pkg::ST_OK;
            a.ident = table_q[i].ident;
            a.duration = table_q[i].duration;
            a.deadline = table_q[i].deadline;
            a.prio = table_q[i].prio;
            a.last = (i == n - 1);
            queue_answer(a);
          end
      end
      ttpo_pkg::FN_ORDER: begin
        if (key == ttpo_pkg::KEY_NONE) queue_answer(plain_answer(ttpo_pkg::ST_BAD));
        else if (n == 0) queue_answer(plain_answer(ttpo_pkg::ST_EMPTY));
        else begin
          for (int i = 1; i < n; i++)
            for (int j = i; j > 0 && sorts_ahead(key, table_q[j], table_q[j-1]); j--) begin
              tmp = table_q[j];
              table_q[j] = table_q[j-1];
              table_q[j-1] = tmp;
            end
          for (int i = 0; i < n; i++) begin
            a = '0;
            a.status = ttpo_pkg::ST_OK;
            a.ident = table_q[i].ident;
            a.last = (i == n - 1);
            queue_answer(a);
          end
        end
      end
      default: queue_answer(plain_answer(ttpo_pkg::ST_BAD));
    endcase
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  task automatic send_request(logic [2:0] fn, logic [15:0] id, logic [15:0] du,
                              logic [15:0] dl, logic [1:0] pr, logic [1:0] key);
    ttpo_pkg::entry_t req;
    int               gap;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.ident = id;
    req.duration = du;
    req.deadline = dl;
    req.prio = pr;
    in_tdata <= {1'b0, key, pr, dl, du, id, fn};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_request(fn, req, key);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_request(int fill_bias);
    logic [2:0]  fn;
    logic [15:0] id;
    int          r;
    r = $urandom_range(0, 99);
    if (r < fill_bias) fn = ttpo_pkg::FN_ADD;
    else if (r < fill_bias + 15) fn = ttpo_pkg::FN_UPD;
    else if (r < fill_bias + 30) fn = ttpo_pkg::FN_DEL;
    else if (r < fill_bias + 38) fn = ttpo_pkg::FN_LIST;
    else if (r < 97) fn = ttpo_pkg::FN_ORDER;
    else fn = 3'($urandom_range(5, 7));
    if (table_q.size() > 0 && $urandom_range(0, 3) != 0)
      id = table_q[$urandom_range(0, table_q.size() - 1)].ident;
    else id = 16'($urandom_range(0, 15)) | ($urandom_range(0, 1) ? 16'($urandom) : 16'h0);
    send_request(fn, id, 16'($urandom_range(0, 7)) ^ ($urandom_range(0, 1) ? 16'($urandom) : 16'h0),
                 16'($urandom_range(0, 7)) ^ ($urandom_range(0, 1) ? 16'($urandom) : 16'h0),
                 2'($urandom),
                 $urandom_range(0, 19) == 0 ? ttpo_pkg::KEY_NONE : 2'($urandom_range(0, 2)));
  endtask

  task automatic test_directed();
    send_request(ttpo_pkg::FN_LIST, 16'h0, 16'h0, 16'h0, 2'd0, ttpo_pkg::KEY_DEADLINE);
    send_request(ttpo_pkg::FN_ORDER, 16'h0, 16'h0, 16'h0, 2'd0, ttpo_pkg::KEY_PRIORITY);
    send_request(ttpo_pkg::FN_ORDER, 16'h0, 16'h0, 16'h0, 2'd0, ttpo_pkg::KEY_NONE);
    send_request(ttpo_pkg::FN_UPD, 16'h1234, 16'h1, 16'h1, 2'd1, 2'd0);
    send_request(ttpo_pkg::FN_DEL, 16'h1234, 16'h0, 16'h0, 2'd0, 2'd0);
    send_request(3'd5, 16'h0, 16'h0, 16'h0, 2'd0, 2'd0);
    send_request(3'd7, 16'hffff, 16'hffff, 16'hffff, 2'd3, 2'd3);
    send_request(ttpo_pkg::FN_ADD, 16'hffff, 16'hffff, 16'h0000, 2'd0, 2'd0);
    send_request(ttpo_pkg::FN_ADD, 16'h0000, 16'h0000, 16'hffff, 2'd3, 2'd0);
    send_request(ttpo_pkg::FN_ADD, 16'h0007, 16'h0005, 16'h0005, 2'd2, 2'd0);
    send_request(ttpo_pkg::FN_ADD, 16'h0007, 16'h0005, 16'h0005, 2'd2, 2'd0);
    send_request(ttpo_pkg::FN_UPD, 16'h0007, 16'h0009, 16'h0001, 2'd1, 2'd0);
    send_request(ttpo_pkg::FN_LIST, 16'h0, 16'h0, 16'h0, 2'd0, 2'd0);
    send_request(ttpo_pkg::FN_ORDER, 16'h0, 16'h0, 16'h0, 2'd0, ttpo_pkg::KEY_DEADLINE);
    send_request(ttpo_pkg::FN_ORDER, 16'h0, 16'h0, 16'h0, 2'd0, ttpo_pkg::KEY_PRIORITY);
    send_request(ttpo_pkg::FN_ORDER, 16'h0, 16'h0, 16'h0, 2'd0, ttpo_pkg::KEY_DURATION);
    send_request(ttpo_pkg::FN_ORDER, 16'h0, 16'h0, 16'h0, 2'd0, ttpo_pkg::KEY_NONE);
    send_request(ttpo_pkg::FN_DEL, 16'h0007, 16'h0, 16'h0, 2'd0, 2'd0);
    send_request(ttpo_pkg::FN_LIST, 16'h0, 16'h0, 16'h0, 2'd0, 2'd0);
    send_request(3'd6, 16'h0, 16'h0, 16'h0, 2'd0, 2'd0);
  endtask

  task automatic test_full_table();
    while (table_q.size() < DEPTH)
      send_request(ttpo_pkg::FN_ADD, 16'($urandom), 16'($urandom_range(0, 3)),
                   16'($urandom_range(0, 3)), 2'($urandom), 2'd0);
    send_request(ttpo_pkg::FN_ADD, 16'h5555, 16'h1, 16'h1, 2'd1, 2'd0);
    send_request(ttpo_pkg::FN_ORDER, 16'h0, 16'h0, 16'h0, 2'd0, ttpo_pkg::KEY_PRIORITY);
    send_request(ttpo_pkg::FN_DEL, table_q[DEPTH-1].ident, 16'h0, 16'h0, 2'd0, 2'd0);
    send_request(ttpo_pkg::FN_LIST, 16'h0, 16'h0, 16'h0, 2'd0, 2'd0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    long_hold_req = !long_hold_req;
    send_request(ttpo_pkg::FN_LIST, 16'h0, 16'h0, 16'h0, 2'd0, 2'd0);
    send_request(ttpo_pkg::FN_ORDER, 16'h0, 16'h0, 16'h0, 2'd0, ttpo_pkg::KEY_DURATION);
    send_request(ttpo_pkg::FN_ADD, 16'h0042, 16'h3, 16'h3, 2'd3, 2'd0);
    wait_drained();
  endtask

  task automatic test_random();
    for (int i = 0; i < 200; i++) begin
      random_request(table_q.size() < 8 ? 50 : 30);
      if (i == 100) wait_drained();
      if (i == 160) begin
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_off <= 0;
    end else if (long_hold_req != long_hold_ack) begin
      long_hold_ack <= long_hold_req;
      hold_off <= 400;
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (recv_gaps && out_tready && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      hold_off <= $urandom_range(0, 18);
    end else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected item", out_tdata[18:3], 16'h0);
      end else begin
        want = answer_q.pop_front();
        if (out_tdata[2:0] !== want.status)
          report_mismatch("status", 16'(out_tdata[2:0]), 16'(want.status));
        if (out_tdata[18:3] !== want.ident) report_mismatch("ident", out_tdata[18:3], want.ident);
        if (out_tdata[34:19] !== want.duration)
          report_mismatch("duration", out_tdata[34:19], want.duration);
        if (out_tdata[50:35] !== want.deadline)
          report_mismatch("deadline", out_tdata[50:35], want.deadline);
        if (out_tdata[52:51] !== want.prio)
          report_mismatch("priority", 16'(out_tdata[52:51]), 16'(want.prio));
        if (out_tdata[55:53] !== 3'd0) report_mismatch("pad", 16'(out_tdata[55:53]), 16'h0);
        if (out_tlast !== want.last) report_mismatch("last", 16'(out_tlast), 16'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("task_table_policy_orderer_core test failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    long_hold_req = 1'b0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_full_table();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (200) @(posedge clk);
    if (error_count == 0 && answer_q.size() == 0)
      $display("task_table_policy_orderer_core test passed");
    else
      $display("task_table_policy_orderer_core test failed");
    $finish;
  end

endmodule
